@@ rtl/core/hpq_pkg.sv @@
// Package for the haptic pulse queue: shared widths, codes and types.
// Used by the top level and the scaler; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

  // Field widths fixed by the interface.
  localparam int DUTY_W     = 8;
  localparam int INTEN_W    = 8;
  localparam int DUR_W      = 16;
  localparam int PCT_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int WAIT_W     = 3;

  // Product of intensity and strength percentage.
  localparam int PROD_W     = INTEN_W + PCT_W;

  localparam logic [PCT_W-1:0]  PCT_FULL = PCT_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  // Default depth of the pulse queue.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = INTEN_W + DUR_W;
  localparam int OUT_DATA_W = 16;

  // Input kind carried on in_tuser.
  localparam logic KIND_BUZZ = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Status code of one result.
  typedef enum logic [STATUS_W-1:0] {
    STAT_TICK     = 3'd0,
    STAT_ACCEPTED = 3'd1,
    STAT_SILENT   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_ZERO     = 3'd4
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_TICK,
    S_EMIT
  } hpq_state_t;

  // One queued pulse.
  typedef struct packed {
    logic [DUR_W-1:0]  ms;
    logic [DUTY_W-1:0] level;
  } pulse_t;

endpackage

`default_nettype wire

@@ rtl/core/haptic_pulse_queue_unit.sv @@
// Vibration-motor pulse scheduler. One item is taken at a time, and the block is
// not ready again until that item's result is in the output register. A millisecond
// tick passes through S_TICK to S_EMIT, and a buzz dropped for zero strength or zero
// duration goes straight to S_EMIT; a buzz that is scaled waits in S_SCALE for two
// passes through one shared multiplier (intensity times strength, then times the
// reciprocal of 100). The next transfer can follow in the cycle after the result
// is loaded. A result still waiting in the output register holds the next result,
// and with it the input, until it is taken.
// Depends on hpq_pkg, hpq_scaler and hpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module haptic_pulse_queue_unit
  import hpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration: strength_percent.
  input  wire logic                  cfg_wr_en,
  input  wire logic [PCT_W-1:0]      cfg_wr_data,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // [7:0] intensity, [23:8] duration
  input  wire logic                  in_tuser,  // kind
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] motor_enable, [8:1] duty, [11:9] status, [14:12] waiting_count, [15] zero
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hpq_state_t         state_r, state_nxt;
  logic [PCT_W-1:0]   strength_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               playing_r, playing_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [DUR_W-1:0]   remain_r, remain_nxt;
  status_t            status_r, status_nxt;
  logic [DUR_W-1:0]   dur_r;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [INTEN_W-1:0] in_inten;
  logic [DUR_W-1:0]   in_dur;
  logic               in_xfer;
  logic               buzz_drop;
  logic               scl_start;
  logic               scl_done;
  logic [DUTY_W-1:0]  scl_level;
  logic               out_load;
  logic               ram_wr_en;
  pulse_t             ram_wr_data;
  pulse_t             ram_rd_data;

  assign in_inten  = in_tdata[INTEN_W-1:0];
  assign in_dur    = in_tdata[INTEN_W +: DUR_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign buzz_drop = (strength_r == '0) || (in_dur == '0);
  assign scl_start = in_xfer && (in_tuser == KIND_BUZZ) && !buzz_drop;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // Shared scaling unit.
  hpq_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scl_start),
    .intensity (in_inten),
    .strength  (strength_r),
    .done      (scl_done),
    .level     (scl_level)
  );

  // Pulse queue storage; the read port always follows the head.
  hpq_ram #(
    .WIDTH ($bits(pulse_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (ram_wr_data),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_TICK) begin
            state_nxt = S_TICK;
          end else if (buzz_drop) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (scl_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_TICK: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Queue and motor updates for each state.
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    playing_nxt  = playing_r;
    duty_nxt     = duty_r;
    remain_nxt   = remain_r;
    status_nxt   = status_r;
    ram_wr_en    = 1'b0;
    ram_wr_data  = '{ms: dur_r, level: scl_level};
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_TICK) begin
            status_nxt = STAT_TICK;
          end else if (strength_r == '0) begin
            status_nxt = STAT_SILENT;
          end else if (in_dur == '0) begin
            status_nxt = STAT_ZERO;
          end
        end
      end
      S_SCALE: begin
        // Start at once when idle and empty, else queue, else drop.
        if (scl_done) begin
          status_nxt = STAT_ACCEPTED;
          if (!playing_r && count_r == '0) begin
            playing_nxt = 1'b1;
            duty_nxt    = scl_level;
            remain_nxt  = dur_r;
          end else if (count_r < CNT_W'(QUEUE_DEPTH)) begin
            ram_wr_en = 1'b1;
            tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
            count_nxt = count_r + CNT_W'(1);
          end else begin
            status_nxt = STAT_FULL;
          end
        end
      end
      S_TICK: begin
        // Count down, stop at zero, then start the oldest waiting pulse.
        if (playing_r) begin
          if (remain_r != '0) begin
            remain_nxt = remain_r - DUR_W'(1);
          end
          if (remain_r <= DUR_W'(1)) begin
            playing_nxt = 1'b0;
            duty_nxt    = '0;
          end
        end
        if ((!playing_r || remain_r <= DUR_W'(1)) && count_r != '0) begin
          playing_nxt = 1'b1;
          duty_nxt    = ram_rd_data.level;
          remain_nxt  = ram_rd_data.ms;
          head_nxt    = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_data_nxt = {1'b0, WAIT_W'(count_r), status_r,
                          playing_r ? duty_r : DUTY_W'(0), playing_r};
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      strength_r  <= PCT_FULL;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      playing_r   <= 1'b0;
      duty_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      playing_r   <= playing_nxt;
      duty_r      <= duty_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      // Strength writes above full scale clamp to full scale.
      if (cfg_wr_en) begin
        strength_r <= (cfg_wr_data > PCT_FULL) ? PCT_FULL : cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    if (in_xfer) begin
      dur_r <= in_dur;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("pulse queue count exceeds depth");

  // Pulses wait only behind a playing pulse.
  a_wait_implies_play: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> playing_r)
    else $error("pulses waiting while motor is off");

  // Duty is zero whenever the motor is off.
  a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
    !playing_r |-> duty_r == '0)
    else $error("nonzero duty while motor is off");

  // The block takes no second item in the cycle after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while an item is in progress");

  // Strength stays within full scale.
  a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
    strength_r <= PCT_FULL)
    else $error("strength above full scale");

endmodule

`default_nettype wire

@@ rtl/core/hpq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the pulse queue entries.
`timescale 1ns / 1ps
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/hpq_scaler.sv @@
// Intensity scaler: one shared multiplier, used first for intensity times strength
// and then for the reciprocal of 100, which gives the truncated quotient.
// Depends on hpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpq_scaler
  import hpq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [INTEN_W-1:0] intensity,
  input  wire logic [PCT_W-1:0]   strength,
  output logic                    done,
  output logic      [DUTY_W-1:0]  level
);

  // 5243 / 2^19 lies close enough to 1/100 that the shifted product equals
  // the truncated quotient for every product up to 255 * 100.
  localparam int                 RECIP_W     = 13;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5243);
  localparam int                 MUL_W       = PROD_W + RECIP_W;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [MUL_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]  mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_p;

  // Shared multiplier: the new item's operands at start, else the held product
  // times the reciprocal.
  assign mul_a = start ? PROD_W'(intensity) : prod_r[PROD_W-1:0];
  assign mul_b = start ? RECIP_W'(strength) : RECIP_100;
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      prod_nxt = mul_p;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
      prod_nxt = mul_p;
    end
  end

  // Sequencer flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working register of the multiplier.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // The quotient sits above the reciprocal's fraction bits once both passes are done.
  assign done  = done_r;
  assign level = (|prod_r[MUL_W-1:RECIP_SHIFT+DUTY_W]) ? DUTY_MAX
                                                       : prod_r[RECIP_SHIFT +: DUTY_W];

endmodule

`default_nettype wire
